[sv/frcc_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// frcc_pkg
// shared constants and types of the framed record checksum check
// ----------------------------------------------------------------------------
package frcc_pkg;

	localparam int HEADER_BYTES = 12;
	localparam int HASH_SHIFT   = 5;
	localparam int WORD_W       = 32;

	// configuration port
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 1;
	typedef logic [CFG_IDX_W-1:0] cfg_idx_t;
	localparam cfg_idx_t CFG_WITH_HEADER = 1'b0;
	localparam cfg_idx_t CFG_SIGN_EXTEND = 1'b1;

	typedef enum logic [1:0] {
		ST_OK       = 2'd0,
		ST_SHORT    = 2'd1,
		ST_MISMATCH = 2'd2
	} status_t;

	typedef struct packed {
		logic with_header;
		logic sign_extend;
	} cfg_t;

	typedef struct packed {
		status_t           status;
		logic [WORD_W-1:0] declared_size;
		logic [WORD_W-1:0] record_version;
		logic [WORD_W-1:0] stored_checksum;
		logic [WORD_W-1:0] hash_value;
	} result_t;

endpackage

[sv/frcc_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// frcc_if
// byte channel and result channel of the framed record checksum check
// ----------------------------------------------------------------------------
interface frcc_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       last_byte;

	modport source (output valid, output data_byte, output last_byte, input ready);
	modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

interface frcc_result_if;
	logic        valid;
	logic        ready;
	logic [1:0]  status;
	logic [31:0] declared_size;
	logic [31:0] record_version;
	logic [31:0] stored_checksum;
	logic [31:0] hash_value;

	modport source (output valid, output status, output declared_size,
		output record_version, output stored_checksum, output hash_value,
		input ready);
	modport sink   (input valid, input status, input declared_size,
		input record_version, input stored_checksum, input hash_value,
		output ready);
endinterface

[sv/frcc_record.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// frcc_record
// per-record state: header capture, byte count and running hash
// ----------------------------------------------------------------------------
module frcc_record (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              step,
	input  logic [7:0]        data_byte,
	input  logic              last_byte,
	input  frcc_pkg::cfg_t    cfg,
	output frcc_pkg::result_t res
);
	import frcc_pkg::*;

	logic [WORD_W-1:0] count_q, size_q, ver_q, chk_q, hash_q;
	logic [WORD_W-1:0] count_n, size_n, ver_n, chk_n, hash_n;
	logic [WORD_W-1:0] ext, hashed, part;
	logic              in_header;

	always_comb begin
		ext       = {{(WORD_W-8){cfg.sign_extend & data_byte[7]}}, data_byte};
		hashed    = ((hash_q << HASH_SHIFT) + hash_q) ^ ext;
		in_header = count_q < WORD_W'(HEADER_BYTES);
		part      = WORD_W'(data_byte) << {count_q[1:0], 3'b000};
		size_n    = size_q;
		ver_n     = ver_q;
		chk_n     = chk_q;
		hash_n    = hash_q;
		if (cfg.with_header) begin
			if (in_header) begin
				case (count_q[3:2])
					2'd0:    size_n = size_q | part;
					2'd1:    ver_n  = ver_q | part;
					default: chk_n  = chk_q | part;
				endcase
			end else if (count_q < size_q) begin
				hash_n = hashed;
			end
		end else begin
			hash_n = hashed;
		end
		// saturating byte position
		count_n = (&count_q) ? count_q : count_q + WORD_W'(1);
	end

	always_comb begin
		if (cfg.with_header) begin
			if (size_n < WORD_W'(HEADER_BYTES) || count_n < size_n) begin
				res.status = ST_SHORT;
			end else if (hash_n != chk_n) begin
				res.status = ST_MISMATCH;
			end else begin
				res.status = ST_OK;
			end
			res.declared_size   = size_n;
			res.record_version  = ver_n;
			res.stored_checksum = chk_n;
		end else begin
			res.status          = ST_OK;
			res.declared_size   = count_n;
			res.record_version  = '0;
			res.stored_checksum = '0;
		end
		res.hash_value = hash_n;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			size_q  <= '0;
			ver_q   <= '0;
			chk_q   <= '0;
			hash_q  <= '0;
		end else if (step) begin
			if (last_byte) begin
				count_q <= '0;
				size_q  <= '0;
				ver_q   <= '0;
				chk_q   <= '0;
				hash_q  <= '0;
			end else begin
				count_q <= count_n;
				size_q  <= size_n;
				ver_q   <= ver_n;
				chk_q   <= chk_n;
				hash_q  <= hash_n;
			end
		end
	end

endmodule

[sv/framed_record_checksum_check.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// framed_record_checksum_check
// checks a framed record byte stream against its header checksum
// ----------------------------------------------------------------------------
// The block takes one byte word per clock and keeps taking one per clock for
// as long as results are taken; a result word is offered once the final byte
// of a record has been accepted into the input register and the record update
// and status logic have loaded the result register. Only when a final byte
// reaches the update stage while the previous result still waits does the byte
// side stall, until that result is taken. In header mode the first twelve
// bytes are the little-endian size, version and checksum words; the bytes
// after them, up to the declared size, go into hash = hash*33 ^ byte. With sign
// extension on, each byte enters the hash as a signed char. Headerless mode
// hashes every byte and reports the received length with status ok. The user
// must write configuration only while the block is idle; nothing enforces it.
// ----------------------------------------------------------------------------
module framed_record_checksum_check (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_we,
	input  frcc_pkg::cfg_idx_t         cfg_index,
	input  logic [frcc_pkg::CFG_DATA_W-1:0] cfg_data,
	frcc_byte_if.sink                  bytes,
	frcc_result_if.source              result
);
	import frcc_pkg::*;

	// configuration registers
	logic with_header_q, sign_extend_q;
	cfg_t cfg;

	// input register
	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       last_s1;

	// result register
	logic    valid_s2;
	result_t res_s2;
	result_t res_next;

	logic advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			with_header_q <= 1'b1;
			sign_extend_q <= 1'b1;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_WITH_HEADER: with_header_q <= cfg_data[0];
				CFG_SIGN_EXTEND: sign_extend_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	assign cfg.with_header = with_header_q;
	assign cfg.sign_extend = sign_extend_q;

	// a byte moves on unless it closes a record while the result waits untaken
	assign advance     = valid_s1 && (!last_s1 || !valid_s2 || result.ready);
	assign bytes.ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (bytes.ready) begin
			valid_s1 <= bytes.valid;
		end
	end

	// payload only, no reset
	always_ff @(posedge clk) begin
		if (bytes.ready && bytes.valid) begin
			byte_s1 <= bytes.data_byte;
			last_s1 <= bytes.last_byte;
		end
	end

	frcc_record u_record (
		.clk       (clk),
		.arst_n    (arst_n),
		.step      (advance),
		.data_byte (byte_s1),
		.last_byte (last_s1),
		.cfg       (cfg),
		.res       (res_next)
	);

	// result register: loads on the final byte of a record
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance && last_s1) begin
			valid_s2 <= 1'b1;
		end else if (result.ready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && last_s1) begin
			res_s2 <= res_next;
		end
	end

	assign result.valid           = valid_s2;
	assign result.status          = res_s2.status;
	assign result.declared_size   = res_s2.declared_size;
	assign result.record_version  = res_s2.record_version;
	assign result.stored_checksum = res_s2.stored_checksum;
	assign result.hash_value      = res_s2.hash_value;

endmodule

[sv/frcc_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// frcc_checker
// port-level checks on the result channel of the checksum check
// ----------------------------------------------------------------------------
module frcc_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        res_valid,
	input  logic        res_ready,
	input  logic [1:0]  status,
	input  logic [31:0] record_version,
	input  logic [31:0] stored_checksum,
	input  logic [31:0] hash_value
);
	import frcc_pkg::*;

	// a waiting result stays up
	a_hold_valid: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid)
		else $error("result dropped while stalled");

	// a waiting result keeps its value
	a_hold_data: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=>
			$stable(status) && $stable(hash_value)
			&& $stable(stored_checksum))
		else $error("result changed while stalled");

	// mismatch only when the words really differ
	a_mismatch: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && status == ST_MISMATCH |->
			stored_checksum != hash_value)
		else $error("mismatch with equal checksums");

	// ok with differing checksums only in headerless mode, which reports zeros
	a_ok_raw: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && status == ST_OK
			&& stored_checksum != hash_value |->
			stored_checksum == '0 && record_version == '0)
		else $error("ok status with checksum mismatch");

endmodule

bind framed_record_checksum_check frcc_checker u_frcc_checker (
	.clk             (clk),
	.arst_n          (arst_n),
	.res_valid       (result.valid),
	.res_ready       (result.ready),
	.status          (result.status),
	.record_version  (result.record_version),
	.stored_checksum (result.stored_checksum),
	.hash_value      (result.hash_value)
);
